[design/at_clp_pkg.sv]
// shared types, constants and defaults for the at command line parser
// no dependencies; imported by every module of the block
package at_clp_pkg;

  localparam int unsigned NumCommandsDef = 16;
  localparam int unsigned NameLenDef     = 16;
  localparam int unsigned MaxParamsDef   = 8;

  // output queue of the block
  localparam int unsigned OutDepth = 4;
  localparam int unsigned OutPtrW  = $clog2(OutDepth);
  localparam int unsigned OutCntW  = $clog2(OutDepth + 1);

  localparam logic [7:0] ChA     = 8'h41;
  localparam logic [7:0] ChT     = 8'h54;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChEq    = 8'h3D;
  localparam logic [7:0] ChComma = 8'h2C;
  localparam logic [7:0] ChNul   = 8'h00;

  localparam logic KindTable  = 1'b0;
  localparam logic KindLine   = 1'b1;
  localparam logic ResParam   = 1'b0;
  localparam logic ResVerdict = 1'b1;

  typedef enum logic [2:0] {
    PH_H0,
    PH_H1,
    PH_H2,
    PH_NAME,
    PH_PARAMS,
    PH_MATCHED,
    PH_FAIL
  } phase_e;

  typedef struct packed {
    logic       kind;
    logic [3:0] entry_index;
    logic [3:0] char_position;
    logic [7:0] byte_value;
    logic       entry_has_params;
    logic       end_of_line;
  } in_item_t;

  typedef struct packed {
    logic       result_kind;
    logic [7:0] param_byte;
    logic [2:0] param_index;
    logic       param_first;
    logic       matched;
    logic [3:0] command_index;
    logic       has_params;
    logic [3:0] param_count;
    logic       last;
  } out_item_t;

  // results of one processed request, res0 goes out first
  typedef struct packed {
    logic [1:0] count;
    out_item_t  res0;
    out_item_t  res1;
  } res_pair_t;

endpackage

[design/at_clp_name_mem.sv]
// name character store: one row per character position, one byte lane per entry
// two registered read ports with write forwarding; uses at_clp_pkg
module at_clp_name_mem import at_clp_pkg::*; #(
  parameter int unsigned NUM_COMMANDS = NumCommandsDef,
  parameter int unsigned NAME_LEN     = NameLenDef,
  localparam int unsigned CW = (NUM_COMMANDS > 1) ? $clog2(NUM_COMMANDS) : 1,
  localparam int unsigned AW = (NAME_LEN > 1) ? $clog2(NAME_LEN) : 1
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         wr_en_i,
  input  logic [AW-1:0]                wr_row_i,
  input  logic [CW-1:0]                wr_lane_i,
  input  logic [7:0]                   wr_data_i,
  input  logic [AW-1:0]                rd_addr_a_i,
  input  logic [AW-1:0]                rd_addr_b_i,
  output logic [NUM_COMMANDS-1:0][7:0] row_a_o,
  output logic [NUM_COMMANDS-1:0][7:0] row_b_o
);

  logic [NUM_COMMANDS-1:0][7:0] mem_q [NAME_LEN];
  logic [NUM_COMMANDS-1:0][7:0] rd_a_q, rd_b_q;
  logic                         fw_a_q, fw_b_q;
  logic [CW-1:0]                fw_lane_q;
  logic [7:0]                   fw_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_row_i][wr_lane_i] <= wr_data_i;
    end
    rd_a_q    <= mem_q[rd_addr_a_i];
    rd_b_q    <= mem_q[rd_addr_b_i];
    fw_lane_q <= wr_lane_i;
    fw_data_q <= wr_data_i;
  end

  // a write landing on the row being read misses the registered read, so it is forwarded here
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_a_q <= 1'b0;
      fw_b_q <= 1'b0;
    end else begin
      fw_a_q <= wr_en_i && (wr_row_i == rd_addr_a_i);
      fw_b_q <= wr_en_i && (wr_row_i == rd_addr_b_i);
    end
  end

  always_comb begin
    row_a_o = rd_a_q;
    row_b_o = rd_b_q;
    if (fw_a_q) begin
      row_a_o[fw_lane_q] = fw_data_q;
    end
    if (fw_b_q) begin
      row_b_o[fw_lane_q] = fw_data_q;
    end
  end

endmodule

[design/at_clp_line_fsm.sv]
// line state machine: header check, name narrowing and resolve, token split,
// verdict, has-params flags and table write decode; uses at_clp_pkg
module at_clp_line_fsm import at_clp_pkg::*; #(
  parameter int unsigned NUM_COMMANDS = NumCommandsDef,
  parameter int unsigned NAME_LEN     = NameLenDef,
  parameter int unsigned MAX_PARAMS   = MaxParamsDef,
  localparam int unsigned CW = (NUM_COMMANDS > 1) ? $clog2(NUM_COMMANDS) : 1,
  localparam int unsigned AW = (NAME_LEN > 1) ? $clog2(NAME_LEN) : 1
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         fire_i,
  input  in_item_t                     item_i,
  input  logic [4:0]                   cmd_count_i,
  input  logic [NUM_COMMANDS-1:0][7:0] row_a_i,
  input  logic [NUM_COMMANDS-1:0][7:0] row_b_i,
  output logic                         wr_en_o,
  output logic [AW-1:0]                wr_row_o,
  output logic [CW-1:0]                wr_lane_o,
  output logic [7:0]                   wr_data_o,
  output logic [AW-1:0]                rd_addr_a_o,
  output logic [AW-1:0]                rd_addr_b_o,
  output res_pair_t                    res_o
);

  localparam int unsigned PW = $clog2(NAME_LEN + 1);
  localparam int unsigned TW = $clog2(MAX_PARAMS + 1);
  localparam logic [PW-1:0] NameLenP  = PW'(NAME_LEN);
  localparam logic [TW-1:0] MaxParamP = TW'(MAX_PARAMS);

  phase_e                  phase_q, phase_d, phase_s;
  logic [PW-1:0]           pos_q, pos_d, pos_s;
  logic [NUM_COMMANDS-1:0] mask_q, mask_d, mask_s;
  logic [CW-1:0]           chosen_q, chosen_d, chosen_s;
  logic [TW-1:0]           tok_q, tok_d, tok_s;
  logic                    in_tok_q, in_tok_d, in_tok_s;
  logic [NUM_COMMANDS-1:0] flags_q, flags_d;

  logic                    line_fire, eol_fire;
  logic [6:0]              entry_ext, lim;
  logic [5:0]              pos_ext;
  logic [NUM_COMMANDS-1:0] in_use;
  logic [CW:0]             res_a, res_e;
  logic                    pb_valid, pb_first;
  logic [PW:0]             pos_next1;
  logic [7:0]              b;

  // lowest entry still in the race whose name ends here
  function automatic logic [CW:0] resolve_f(
    input logic [NUM_COMMANDS-1:0]      mask,
    input logic [NUM_COMMANDS-1:0]      use_vec,
    input logic [NUM_COMMANDS-1:0][7:0] row,
    input logic                         at_end
  );
    logic [CW:0] r;
    r = '0;
    for (int i = NUM_COMMANDS - 1; i >= 0; i--) begin
      if (mask[i] && use_vec[i] && (at_end || row[i] == ChNul)) begin
        r = {1'b1, CW'(i)};
      end
    end
    return r;
  endfunction

  function automatic phase_e resolved_phase(input logic found, input logic saw_eq,
                                            input logic flag);
    phase_e p;
    if (!found) begin
      p = PH_FAIL;
    end else if (saw_eq && flag) begin
      p = PH_PARAMS;
    end else begin
      p = PH_MATCHED;
    end
    return p;
  endfunction

  assign b         = item_i.byte_value;
  assign line_fire = fire_i && (item_i.kind == KindLine);
  assign eol_fire  = line_fire && item_i.end_of_line;
  assign entry_ext = {3'b000, item_i.entry_index};
  assign pos_ext   = {2'b00, item_i.char_position};
  assign lim       = ({2'b00, cmd_count_i} < 7'(NUM_COMMANDS)) ? {2'b00, cmd_count_i}
                                                               : 7'(NUM_COMMANDS);

  always_comb begin
    for (int i = 0; i < NUM_COMMANDS; i++) begin
      in_use[i] = 7'(i) < lim;
    end
  end

  // table write decode, out of range positions or entries are dropped
  assign wr_en_o   = fire_i && (item_i.kind == KindTable)
                     && (entry_ext < 7'(NUM_COMMANDS)) && (pos_ext < 6'(NAME_LEN));
  assign wr_row_o  = pos_ext[AW-1:0];
  assign wr_lane_o = entry_ext[CW-1:0];
  assign wr_data_o = b;

  // effect of the byte itself, before any end of line handling
  always_comb begin
    phase_s  = phase_q;
    pos_s    = pos_q;
    mask_s   = mask_q;
    chosen_s = chosen_q;
    tok_s    = tok_q;
    in_tok_s = in_tok_q;
    pb_valid = 1'b0;
    pb_first = 1'b0;
    res_e    = '0;
    res_a    = resolve_f(mask_q, in_use, row_a_i, pos_q >= NameLenP);
    if (line_fire) begin
      case (phase_q)
        PH_H0: begin
          phase_s = (b == ChA) ? PH_H1 : PH_FAIL;
        end
        PH_H1: begin
          phase_s = (b == ChT) ? PH_H2 : PH_FAIL;
        end
        PH_H2: begin
          if (b == ChPlus) begin
            phase_s = PH_NAME;
            pos_s   = '0;
            mask_s  = '1;
          end else begin
            phase_s = PH_FAIL;
          end
        end
        PH_NAME: begin
          if (b == ChEq || b == ChNul) begin
            chosen_s = res_a[CW] ? res_a[CW-1:0] : '0;
            phase_s  = resolved_phase(res_a[CW], b == ChEq, flags_q[res_a[CW-1:0]]);
          end else if (pos_q >= NameLenP) begin
            mask_s = '0;
          end else begin
            for (int i = 0; i < NUM_COMMANDS; i++) begin
              if (in_use[i] && row_a_i[i] != b) begin
                mask_s[i] = 1'b0;
              end
            end
            pos_s = pos_q + PW'(1);
          end
        end
        PH_PARAMS: begin
          if (b == ChNul) begin
            phase_s = PH_MATCHED;
          end else if (b == ChComma) begin
            if (in_tok_q) begin
              in_tok_s = 1'b0;
              if (tok_q >= MaxParamP) begin
                phase_s = PH_MATCHED;
              end
            end
          end else begin
            pb_valid = 1'b1;
            pb_first = !in_tok_q;
            if (!in_tok_q) begin
              tok_s    = tok_q + TW'(1);
              in_tok_s = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
      // line ending inside the name: resolve at the position just reached
      if (item_i.end_of_line && phase_s == PH_NAME) begin
        res_e    = resolve_f(mask_s, in_use, (pos_s == pos_q) ? row_a_i : row_b_i,
                             pos_s >= NameLenP);
        chosen_s = res_e[CW] ? res_e[CW-1:0] : '0;
        phase_s  = resolved_phase(res_e[CW], 1'b0, 1'b0);
      end
    end
  end

  always_comb begin
    flags_d = flags_q;
    if (wr_en_o) begin
      flags_d[wr_lane_o] = item_i.entry_has_params;
    end
    if (eol_fire) begin
      phase_d  = PH_H0;
      pos_d    = '0;
      mask_d   = '1;
      chosen_d = '0;
      tok_d    = '0;
      in_tok_d = 1'b0;
    end else begin
      phase_d  = phase_s;
      pos_d    = pos_s;
      mask_d   = mask_s;
      chosen_d = chosen_s;
      tok_d    = tok_s;
      in_tok_d = in_tok_s;
    end
  end

  // rows for the next request: current position and the one after
  assign pos_next1   = {1'b0, pos_d} + (PW+1)'(1);
  assign rd_addr_a_o = (pos_d < NameLenP) ? pos_d[AW-1:0] : '0;
  assign rd_addr_b_o = (pos_next1 < (PW+1)'(NAME_LEN)) ? pos_next1[AW-1:0] : '0;

  always_comb begin
    out_item_t pbyte, verdict;
    logic      m;
    m = (phase_s == PH_PARAMS) || (phase_s == PH_MATCHED);

    pbyte               = '0;
    pbyte.result_kind   = ResParam;
    pbyte.param_byte    = b;
    pbyte.param_index   = 3'(4'(tok_s) - 4'd1);
    pbyte.param_first   = pb_first;
    pbyte.last          = !item_i.end_of_line;

    verdict               = '0;
    verdict.result_kind   = ResVerdict;
    verdict.matched       = m;
    verdict.command_index = m ? 4'(chosen_s) : 4'd0;
    verdict.has_params    = m && flags_q[chosen_s];
    verdict.param_count   = m ? 4'(tok_s) : 4'd0;
    verdict.last          = 1'b1;

    res_o       = '0;
    res_o.res1  = verdict;
    res_o.res0  = pb_valid ? pbyte : verdict;
    if (line_fire) begin
      res_o.count = {1'b0, pb_valid} + {1'b0, item_i.end_of_line};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_H0;
      pos_q    <= '0;
      mask_q   <= '1;
      chosen_q <= '0;
      tok_q    <= '0;
      in_tok_q <= 1'b0;
      flags_q  <= '0;
    end else begin
      phase_q  <= phase_d;
      pos_q    <= pos_d;
      mask_q   <= mask_d;
      chosen_q <= chosen_d;
      tok_q    <= tok_d;
      in_tok_q <= in_tok_d;
      flags_q  <= flags_d;
    end
  end

endmodule

[design/at_clp_out_fifo.sv]
// result queue: takes up to two results a cycle, hands out one
// uses at_clp_pkg for the result types and depth
module at_clp_out_fifo import at_clp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  res_pair_t res_i,
  output logic      space_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_res_o
);

  out_item_t            buf_q [OutDepth];
  logic [OutPtrW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d, wr_ptr_nx;
  logic [OutCntW-1:0]   cnt_q, cnt_d;
  logic                 pop;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = cnt_q != '0;
  assign out_res_o   = buf_q[rd_ptr_q];
  // room for a full pair from the next request
  assign space_o     = cnt_q <= OutCntW'(OutDepth - 2);
  assign wr_ptr_nx   = wr_ptr_q + OutPtrW'(1);
  assign wr_ptr_d    = wr_ptr_q + OutPtrW'(res_i.count);
  assign rd_ptr_d    = rd_ptr_q + OutPtrW'(pop);
  assign cnt_d       = cnt_q + OutCntW'(res_i.count) - OutCntW'(pop);

  always_ff @(posedge clk_i) begin
    if (res_i.count != 2'd0) begin
      buf_q[wr_ptr_q] <= res_i.res0;
    end
    if (res_i.count == 2'd2) begin
      buf_q[wr_ptr_nx] <= res_i.res1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

[design/at_command_line_parser_top.sv]
// a request waits in the input register until the result queue has room for its results
// throughput: one request per cycle while the queue has room; output carries one result per
//   cycle while taken; two results go out in turn, a 4-entry result queue absorbs this
// name rows are read ahead into registers from a two-read-port memory with write forwarding
// reset is asynchronous, active low: line state to header start, command count and
//   has-params flags to zero; the name memory is not cleared and holds garbage until written
module at_command_line_parser_top import at_clp_pkg::*; #(
  parameter int unsigned NUM_COMMANDS = NumCommandsDef,
  parameter int unsigned NAME_LEN     = NameLenDef,
  parameter int unsigned MAX_PARAMS   = MaxParamsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_req_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_res_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic [4:0] cfg_data_i
);

  localparam int unsigned CW = (NUM_COMMANDS > 1) ? $clog2(NUM_COMMANDS) : 1;
  localparam int unsigned AW = (NAME_LEN > 1) ? $clog2(NAME_LEN) : 1;

  logic                         in_valid_q;
  in_item_t                     in_item_q;
  logic [4:0]                   cmd_count_q;
  logic                         space, fire;
  logic                         wr_en;
  logic [AW-1:0]                wr_row, rd_addr_a, rd_addr_b;
  logic [CW-1:0]                wr_lane;
  logic [7:0]                   wr_data;
  logic [NUM_COMMANDS-1:0][7:0] row_a, row_b;
  res_pair_t                    res;

  assign fire        = in_valid_q && space;
  assign in_ready_o  = !in_valid_q || fire;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_item_q <= in_req_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      cmd_count_q <= '0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        in_valid_q <= 1'b1;
      end else if (fire) begin
        in_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        cmd_count_q <= cfg_data_i;
      end
    end
  end

  at_clp_name_mem #(
    .NUM_COMMANDS(NUM_COMMANDS),
    .NAME_LEN    (NAME_LEN)
  ) u_name_mem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (wr_en),
    .wr_row_i   (wr_row),
    .wr_lane_i  (wr_lane),
    .wr_data_i  (wr_data),
    .rd_addr_a_i(rd_addr_a),
    .rd_addr_b_i(rd_addr_b),
    .row_a_o    (row_a),
    .row_b_o    (row_b)
  );

  at_clp_line_fsm #(
    .NUM_COMMANDS(NUM_COMMANDS),
    .NAME_LEN    (NAME_LEN),
    .MAX_PARAMS  (MAX_PARAMS)
  ) u_line_fsm (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .item_i     (in_item_q),
    .cmd_count_i(cmd_count_q),
    .row_a_i    (row_a),
    .row_b_i    (row_b),
    .wr_en_o    (wr_en),
    .wr_row_o   (wr_row),
    .wr_lane_o  (wr_lane),
    .wr_data_o  (wr_data),
    .rd_addr_a_o(rd_addr_a),
    .rd_addr_b_o(rd_addr_b),
    .res_o      (res)
  );

  at_clp_out_fifo u_out_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .res_i      (res),
    .space_o    (space),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_res_o  (out_res_o)
  );

endmodule

[design/at_clp_checker.sv]
// port-level checks for the at command line parser, bound to the top level
// uses at_clp_pkg for result types and character codes
module at_clp_checker import at_clp_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_res_o
);

  // a waiting result holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_res_o))
    else $error("result changed or dropped while stalled");

  // a verdict always closes the results of its request
  a_verdict_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_res_o.result_kind == ResVerdict |-> out_res_o.last)
    else $error("verdict without last");

  // parameter bytes never carry separators, terminators or verdict fields
  a_param_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_res_o.result_kind == ResParam |->
      out_res_o.param_byte != ChNul && out_res_o.param_byte != ChComma
      && !out_res_o.matched && out_res_o.param_count == 4'd0)
    else $error("bad parameter byte result");

  // a failed line reports nothing else
  a_fail_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_res_o.result_kind == ResVerdict && !out_res_o.matched |->
      out_res_o.command_index == 4'd0 && !out_res_o.has_params
      && out_res_o.param_count == 4'd0)
    else $error("failed line verdict carries data");

endmodule

bind at_command_line_parser_top at_clp_checker u_at_clp_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_res_o  (out_res_o)
);

[verif/at_command_line_parser_top_tb.sv]
// self-checking testbench for at_command_line_parser_top: table fill, directed lines, random lines
// keeps its own line parser model and compares every result request in order
// depends on at_clp_pkg and the top module only
module at_command_line_parser_top_tb;
  import at_clp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NC = NumCommandsDef;
  localparam int unsigned NL = NameLenDef;
  localparam int unsigned MP = MaxParamsDef;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned StallLimit = 2000;
  localparam int unsigned ItemsPerPhase = 110;
  localparam int unsigned NPhases = 7;
  localparam logic [7:0] NameAlpha [4] = '{8'h43, 8'h4D, 8'h44, 8'h45};

  typedef enum {ByPredictor, FailedLine, EntryZeroNoTokens} dir_check_e;

  // rows before FirstFilledRow run on the empty table with command count zero
  localparam int unsigned NDir = 11;
  localparam int unsigned FirstFilledRow = 3;
  string dir_text [NDir] = '{
    "AT+Q", "B", "A",
    "AT+C", "AT+C=,x,,yz,", "AT+CD#Z=9", "AT+=", "AT+CMDCMDCMDCMDCMDCM",
    "AT+C=\377\001", "AT-C", "AT+CD=1"
  };
  dir_check_e dir_check [NDir] = '{
    FailedLine, FailedLine, FailedLine,
    EntryZeroNoTokens, ByPredictor, ByPredictor, FailedLine, FailedLine,
    ByPredictor, FailedLine, ByPredictor
  };

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  in_item_t   in_req = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_item_t  out_res;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [4:0] cfg_data = '0;

  at_command_line_parser_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_res_o   (out_res),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // parser model state
  logic [7:0]    name_tab [NC][NL];
  bit            entry_flags [NC];
  phase_e        ln_phase;
  int unsigned   ln_pos;
  logic [NC-1:0] cand;
  logic [3:0]    chosen;
  int unsigned   tok_cnt;
  bit            in_tok;
  logic [4:0]    cmd_count = '0;

  out_item_t   step_res [2];
  int unsigned step_n;
  out_item_t   exp_q [$];

  logic [7:0]  line_buf [$];
  bit          quiet = 1'b0;
  int unsigned n_items = 0;
  int unsigned failures = 0;
  int unsigned stall_cycles = 0;

  function automatic int unsigned in_use();
    return (cmd_count < NC) ? cmd_count : NC;
  endfunction

  function automatic void line_reset();
    ln_phase = PH_H0;
    ln_pos   = 0;
    cand     = '1;
    chosen   = '0;
    tok_cnt  = 0;
    in_tok   = 1'b0;
  endfunction

  function automatic void filter_candidates(logic [7:0] b);
    if (ln_pos >= NL) begin
      cand = '0;
    end else begin
      for (int i = 0; i < in_use(); i++)
        if (name_tab[i][ln_pos] != b) cand[i] = 1'b0;
      ln_pos++;
    end
  endfunction

  // first surviving entry whose name ends here wins
  function automatic void settle_name(bit saw_eq);
    bit found;
    found = 1'b0;
    for (int i = 0; i < in_use() && !found; i++) begin
      if (cand[i] && (ln_pos >= NL || name_tab[i][ln_pos] == ChNul)) begin
        found  = 1'b1;
        chosen = 4'(i);
        if (saw_eq && entry_flags[i]) begin
          ln_phase = PH_PARAMS;
          tok_cnt  = 0;
          in_tok   = 1'b0;
        end else begin
          ln_phase = PH_MATCHED;
        end
      end
    end
    if (!found) begin
      chosen   = '0;
      ln_phase = PH_FAIL;
    end
  endfunction

  function automatic void advance_parser(in_item_t r);
    out_item_t res;
    step_n = 0;
    if (r.kind == KindTable) begin
      name_tab[r.entry_index][r.char_position] = r.byte_value;
      entry_flags[r.entry_index] = r.entry_has_params;
      return;
    end
    case (ln_phase)
      PH_H0: ln_phase = (r.byte_value == ChA) ? PH_H1 : PH_FAIL;
      PH_H1: ln_phase = (r.byte_value == ChT) ? PH_H2 : PH_FAIL;
      PH_H2: begin
        if (r.byte_value == ChPlus) begin
          ln_phase = PH_NAME;
          ln_pos   = 0;
          cand     = '1;
        end else begin
          ln_phase = PH_FAIL;
        end
      end
      PH_NAME: begin
        if (r.byte_value == ChEq) settle_name(1'b1);
        else if (r.byte_value == ChNul) settle_name(1'b0);
        else filter_candidates(r.byte_value);
      end
      PH_PARAMS: begin
        if (r.byte_value == ChNul) begin
          ln_phase = PH_MATCHED;
        end else if (r.byte_value == ChComma) begin
          // empty tokens are skipped, the token limit closes at a comma
          if (in_tok) begin
            in_tok = 1'b0;
            if (tok_cnt >= MP) ln_phase = PH_MATCHED;
          end
        end else begin
          res = '0;
          res.result_kind = ResParam;
          res.param_byte  = r.byte_value;
          res.param_first = !in_tok;
          if (!in_tok) begin
            tok_cnt++;
            in_tok = 1'b1;
          end
          res.param_index = 3'(tok_cnt - 1);
          step_res[step_n] = res;
          step_n++;
        end
      end
      default: ;
    endcase
    if (r.end_of_line) begin
      if (ln_phase == PH_NAME) settle_name(1'b0);
      res = '0;
      res.result_kind = ResVerdict;
      if (ln_phase == PH_PARAMS || ln_phase == PH_MATCHED) begin
        res.matched       = 1'b1;
        res.command_index = chosen;
        res.has_params    = entry_flags[chosen];
        res.param_count   = 4'(tok_cnt);
      end
      step_res[step_n] = res;
      step_n++;
      line_reset();
    end
    if (step_n > 0) step_res[step_n - 1].last = 1'b1;
  endfunction

  function automatic logic [7:0] name_char();
    return NameAlpha[$urandom_range(3)];
  endfunction

  function automatic logic [7:0] param_char();
    return ($urandom_range(4) == 0) ? 8'($urandom_range(1, 255)) : 8'($urandom_range(33, 126));
  endfunction

  function automatic string random_name();
    string s;
    int unsigned len;
    s = "";
    len = ($urandom_range(6) == 0) ? NL : $urandom_range(1, 5);
    repeat (len) s = $sformatf("%s%c", s, name_char());
    return s;
  endfunction

  function automatic string show(out_item_t r);
    return $sformatf("kind %0d byte %02h idx %0d first %0d match %0d cmd %0d hp %0d cnt %0d last %0d",
                     r.result_kind, r.param_byte, r.param_index, r.param_first, r.matched,
                     r.command_index, r.has_params, r.param_count, r.last);
  endfunction

  // mostly well-formed lines built from the current table, the rest broken or noise
  function automatic void compose_line();
    logic [7:0]  nm [$];
    logic [7:0]  hdr [3];
    logic [7:0]  b;
    int unsigned e, len, roll, ntok;
    line_buf.delete();
    hdr  = '{ChA, ChT, ChPlus};
    roll = $urandom_range(99);
    if (roll < 74) begin
      line_buf = '{ChA, ChT, ChPlus};
      e = $urandom_range(NC - 1);
      for (int p = 0; p < NL && name_tab[e][p] != ChNul; p++) nm.push_back(name_tab[e][p]);
      case ($urandom_range(9))
        0: if (nm.size() > 1) void'(nm.pop_back());
        1: nm.push_back(name_char());
        2: if (nm.size() > 0) nm[$urandom_range(nm.size() - 1)] = name_char();
        3: while (nm.size() <= NL) nm.push_back(name_char());
        default: ;
      endcase
      line_buf = {line_buf, nm};
      if ($urandom_range(9) < 8) begin
        line_buf.push_back(ChEq);
        ntok = ($urandom_range(3) == 0) ? $urandom_range(12) : $urandom_range(4);
        for (int t = 0; t < ntok; t++) begin
          if (t > 0 || $urandom_range(4) == 0) line_buf.push_back(ChComma);
          repeat ($urandom_range(3)) line_buf.push_back(param_char());
        end
        if ($urandom_range(7) == 0) line_buf.push_back(ChComma);
      end
      if ($urandom_range(11) == 0) begin
        line_buf.insert($urandom_range(3, line_buf.size()), ChNul);
        repeat ($urandom_range(2)) line_buf.push_back(param_char());
      end
    end else if (roll < 86) begin
      len = $urandom_range(2);
      for (int k = 0; k < len; k++) line_buf.push_back(hdr[k]);
      if (len == 0 || $urandom_range(2) != 0) begin
        b = 8'($urandom);
        line_buf.push_back((b == hdr[len]) ? (b ^ 8'h01) : b);
      end
      repeat ($urandom_range(4)) line_buf.push_back(8'($urandom));
    end else begin
      repeat ($urandom_range(1, 8)) line_buf.push_back(8'($urandom));
    end
  endfunction

  task automatic send_request(in_item_t r, bit use_want, out_item_t want);
    while (!quiet && $urandom_range(99) < 29) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    do @(posedge clk); while (!in_ready);
    n_items++;
    advance_parser(r);
    for (int k = 0; k < step_n; k++)
      exp_q.push_back((use_want && k == step_n - 1) ? want : step_res[k]);
  endtask

  task automatic write_name(int unsigned e, string s, bit hp);
    in_item_t r;
    for (int p = 0; p < NL; p++) begin
      r.kind             = KindTable;
      r.entry_index      = 4'(e);
      r.char_position    = 4'(p);
      r.entry_has_params = hp;
      r.end_of_line      = 1'($urandom);
      if (p < s.len()) r.byte_value = s[p];
      else if (p == s.len()) r.byte_value = ChNul;
      else r.byte_value = 8'($urandom);
      send_request(r, 1'b0, '0);
    end
  endtask

  task automatic send_line(bit mix, bit use_want, out_item_t want);
    in_item_t r;
    for (int i = 0; i < line_buf.size(); i++) begin
      // table request slipped into the line
      if (mix && $urandom_range(39) == 0) begin
        r.kind             = KindTable;
        r.entry_index      = 4'($urandom);
        r.char_position    = 4'($urandom);
        r.byte_value       = ($urandom_range(2) == 0) ? 8'($urandom) : name_char();
        r.entry_has_params = 1'($urandom);
        r.end_of_line      = 1'($urandom);
        send_request(r, 1'b0, '0);
      end
      r.kind             = KindLine;
      r.entry_index      = 4'($urandom);
      r.char_position    = 4'($urandom);
      r.byte_value       = line_buf[i];
      r.entry_has_params = 1'($urandom);
      r.end_of_line      = (i == line_buf.size() - 1);
      send_request(r, use_want, want);
    end
  endtask

  task automatic drain_and_configure(logic [4:0] v);
    in_valid <= 1'b0;
    while (exp_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cmd_count = v;
  endtask

  always @(posedge clk) begin
    out_item_t head;
    if (rst_n && out_valid && out_ready) begin
      if (exp_q.size() == 0) begin
        failures++;
        if (failures <= 10) $display("unexpected result: %s", show(out_res));
      end else begin
        head = exp_q.pop_front();
        if (out_res !== head) begin
          failures++;
          if (failures <= 10) $display("mismatch\n  exp %s\n  got %s", show(head), show(out_res));
        end
      end
    end
    out_ready <= quiet || ($urandom_range(99) >= 29);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles == StallLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    out_item_t   want;
    logic [4:0]  phase_count [NPhases];
    int unsigned budget;
    string       txt;
    line_reset();
    phase_count = '{5'd16, 5'd1, 5'd0, 5'($urandom_range(2, 15)), 5'd17, 5'd31, 5'($urandom)};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < NDir; i++) begin
      if (i == FirstFilledRow) begin
        // every name character is written before any entry comes into use
        write_name(0, "C", 1'b1);
        write_name(1, "C", 1'b0);
        write_name(2, "CD", 1'b0);
        write_name(3, "CMDCMDCMDCMDCMDC", 1'b1);
        for (int e = 4; e < NC; e++) write_name(e, random_name(), 1'($urandom));
        drain_and_configure(5'd31);
      end
      txt = dir_text[i];
      line_buf.delete();
      for (int k = 0; k < txt.len(); k++)
        line_buf.push_back((txt[k] == "#") ? ChNul : txt[k]);
      want = '0;
      want.result_kind = ResVerdict;
      want.last        = 1'b1;
      if (dir_check[i] == EntryZeroNoTokens) begin
        want.matched    = 1'b1;
        want.has_params = 1'b1;
      end
      send_line(1'b0, dir_check[i] != ByPredictor, want);
    end

    for (int ph = 0; ph < NPhases; ph++) begin
      drain_and_configure(phase_count[ph]);
      quiet  = (ph == 3);
      budget = n_items + ItemsPerPhase;
      while (n_items < budget) begin
        if ($urandom_range(19) == 0) begin
          write_name($urandom_range(NC - 1), random_name(), 1'($urandom));
        end else begin
          compose_line();
          send_line(1'b1, 1'b0, '0);
        end
      end
    end
    quiet = 1'b0;
    in_valid <= 1'b0;

    while (exp_q.size() != 0) @(posedge clk);
    repeat (2 * DrainCycles) @(posedge clk);
    if (failures == 0 && exp_q.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
